// File: src/mi3_pkg.sv
// Shared widths, types and cofactor index tables for the 3x3 matrix inverse.
`default_nettype none
package mi3_pkg;

  // element format
  localparam int EW = 32;
  localparam int FB = 16;
  localparam int NE = 9;

  // derived widths
  localparam int PROD_W = 2 * EW;
  localparam int ADJ_W  = 2 * EW + 1;
  localparam int PART_W = 2 * EW + 1;
  localparam int DET_W  = 3 * EW + 2;
  localparam int NUM_W  = ADJ_W + 2 * FB;
  localparam int Q_BITS = EW + 1;

  typedef logic signed [EW-1:0]     elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;
  typedef logic signed [PART_W-1:0] part_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [ADJ_W-1:0]         amag_t;
  typedef logic [DET_W-1:0]         dmag_t;
  typedef logic [Q_BITS-1:0]        quo_t;

  // saturation limits
  localparam quo_t  Q_HALF   = quo_t'(1) << (EW - 1);
  localparam elem_t ELEM_MAX = elem_t'((quo_t'(1) << (EW - 1)) - quo_t'(1));
  localparam elem_t ELEM_MIN = elem_t'(quo_t'(1) << (EW - 1));

  // adjugate entry k = m[PA]*m[PB] - m[PC]*m[PD]
  localparam logic [3:0] ADJ_PA [NE] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] ADJ_PB [NE] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] ADJ_PC [NE] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] ADJ_PD [NE] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  typedef struct packed {
    logic valid;
    logic singular;
  } item_ctl_t;

  typedef struct packed {
    logic neg;
    logic ovf;
  } lane_side_t;

  typedef struct packed {
    elem_t [NE-1:0] inv;
    logic           singular;
    logic           overflow;
  } res_t;

endpackage
`default_nettype wire

// File: src/mi3_cofactor.sv
// Cofactor and determinant pipeline: six stages from elements to magnitudes.
`default_nettype none
module mi3_cofactor (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                valid_i,
  input  wire mi3_pkg::elem_t      elem_i [mi3_pkg::NE],
  output mi3_pkg::item_ctl_t       ctl_o,
  output logic                     lane_neg_o [mi3_pkg::NE],
  output mi3_pkg::amag_t           adj_mag_o [mi3_pkg::NE],
  output mi3_pkg::dmag_t           det_mag_o
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  mi3_pkg::prod_t prod_r [2*mi3_pkg::NE];
  mi3_pkg::prod_t prod_nxt [2*mi3_pkg::NE];
  mi3_pkg::elem_t m1_r [3];
  mi3_pkg::elem_t m2_r [3];
  mi3_pkg::adj_t  adj2_r [mi3_pkg::NE];
  mi3_pkg::adj_t  adj3_r [mi3_pkg::NE];
  mi3_pkg::adj_t  adj4_r [mi3_pkg::NE];
  mi3_pkg::adj_t  adj5_r [mi3_pkg::NE];
  mi3_pkg::part_t lo_r [3];
  mi3_pkg::part_t hi_r [3];
  mi3_pkg::det_t  term_r [3];
  mi3_pkg::det_t  det_r;
  mi3_pkg::item_ctl_t ctl_r;
  logic           lane_neg_r [mi3_pkg::NE];
  mi3_pkg::amag_t adj_mag_r [mi3_pkg::NE];
  mi3_pkg::dmag_t det_mag_r;

  // form the 18 element products
  always_comb begin
    for (int k = 0; k < mi3_pkg::NE; k++) begin
      prod_nxt[2*k]   = mi3_pkg::prod_t'(elem_i[mi3_pkg::ADJ_PA[k]])
                      * mi3_pkg::prod_t'(elem_i[mi3_pkg::ADJ_PB[k]]);
      prod_nxt[2*k+1] = mi3_pkg::prod_t'(elem_i[mi3_pkg::ADJ_PC[k]])
                      * mi3_pkg::prod_t'(elem_i[mi3_pkg::ADJ_PD[k]]);
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      ctl_r <= '0;
    end else if (adv) begin
      v1_r           <= valid_i;
      v2_r           <= v1_r;
      v3_r           <= v2_r;
      v4_r           <= v3_r;
      v5_r           <= v4_r;
      ctl_r.valid    <= v5_r;
      ctl_r.singular <= (det_r == '0);
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2*mi3_pkg::NE; k++) prod_r[k] <= prod_nxt[k];
      for (int k = 0; k < 3; k++) begin
        m1_r[k] <= elem_i[k];
        m2_r[k] <= m1_r[k];
      end
      // adjugate entries
      for (int k = 0; k < mi3_pkg::NE; k++) begin
        adj2_r[k] <= mi3_pkg::adj_t'(prod_r[2*k]) - mi3_pkg::adj_t'(prod_r[2*k+1]);
        adj3_r[k] <= adj2_r[k];
        adj4_r[k] <= adj3_r[k];
        adj5_r[k] <= adj4_r[k];
      end
      // split first-row products into low and high halves of the cofactor
      for (int k = 0; k < 3; k++) begin
        lo_r[k] <= mi3_pkg::part_t'(m2_r[k])
                 * mi3_pkg::part_t'($signed({1'b0, adj2_r[3*k][mi3_pkg::EW-1:0]}));
        hi_r[k] <= mi3_pkg::part_t'(m2_r[k])
                 * mi3_pkg::part_t'($signed(adj2_r[3*k][mi3_pkg::ADJ_W-1:mi3_pkg::EW]));
        term_r[k] <= (mi3_pkg::det_t'(hi_r[k]) <<< mi3_pkg::EW) + mi3_pkg::det_t'(lo_r[k]);
      end
      det_r <= term_r[0] + term_r[1] + term_r[2];
      // magnitudes and quotient signs
      det_mag_r <= det_r[mi3_pkg::DET_W-1] ? mi3_pkg::dmag_t'(-det_r) : mi3_pkg::dmag_t'(det_r);
      for (int k = 0; k < mi3_pkg::NE; k++) begin
        adj_mag_r[k]  <= adj5_r[k][mi3_pkg::ADJ_W-1] ? mi3_pkg::amag_t'(-adj5_r[k])
                                                      : mi3_pkg::amag_t'(adj5_r[k]);
        lane_neg_r[k] <= adj5_r[k][mi3_pkg::ADJ_W-1] ^ det_r[mi3_pkg::DET_W-1];
      end
    end
  end

  assign ctl_o      = ctl_r;
  assign lane_neg_o = lane_neg_r;
  assign adj_mag_o  = adj_mag_r;
  assign det_mag_o  = det_mag_r;

endmodule
`default_nettype wire

// File: src/mi3_divider.sv
// Nine-lane pipelined restoring divider: range check stage, then one quotient bit per stage.
`default_nettype none
module mi3_divider (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire mi3_pkg::item_ctl_t  ctl_i,
  input  wire logic                lane_neg_i [mi3_pkg::NE],
  input  wire mi3_pkg::amag_t      adj_mag_i [mi3_pkg::NE],
  input  wire mi3_pkg::dmag_t      det_mag_i,
  output mi3_pkg::item_ctl_t       ctl_o,
  output mi3_pkg::lane_side_t      side_o [mi3_pkg::NE],
  output mi3_pkg::quo_t            quo_o [mi3_pkg::NE]
);

  localparam int QB    = mi3_pkg::Q_BITS;
  localparam int PRE_W = mi3_pkg::NUM_W - QB;
  localparam int CMP_W = (PRE_W > mi3_pkg::DET_W) ? PRE_W : mi3_pkg::DET_W;

  mi3_pkg::item_ctl_t  ctl_r  [QB+1];
  mi3_pkg::lane_side_t side_r [QB+1][mi3_pkg::NE];
  mi3_pkg::quo_t       quo_r  [QB+1][mi3_pkg::NE];
  mi3_pkg::dmag_t      rem_r  [QB][mi3_pkg::NE];
  mi3_pkg::quo_t       low_r  [QB][mi3_pkg::NE];
  mi3_pkg::dmag_t      dsr_r  [QB];

  logic [mi3_pkg::NUM_W-1:0] num_nxt [mi3_pkg::NE];
  logic [PRE_W-1:0]          pre_nxt [mi3_pkg::NE];

  // scale numerator, flag quotients too large for the bit budget
  always_comb begin
    for (int l = 0; l < mi3_pkg::NE; l++) begin
      num_nxt[l] = mi3_pkg::NUM_W'(adj_mag_i[l]) << (2 * mi3_pkg::FB);
      pre_nxt[l] = num_nxt[l][mi3_pkg::NUM_W-1:QB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (adv) begin
      ctl_r[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dsr_r[0] <= det_mag_i;
      for (int l = 0; l < mi3_pkg::NE; l++) begin
        side_r[0][l].neg <= lane_neg_i[l];
        side_r[0][l].ovf <= CMP_W'(pre_nxt[l]) >= CMP_W'(det_mag_i);
        rem_r[0][l]      <= mi3_pkg::DET_W'(pre_nxt[l]);
        low_r[0][l]      <= num_nxt[l][QB-1:0];
        quo_r[0][l]      <= '0;
      end
    end
  end

  // one restoring step per stage
  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [mi3_pkg::DET_W:0] trial [mi3_pkg::NE];
    logic                    ge    [mi3_pkg::NE];
    mi3_pkg::dmag_t          rem_nxt [mi3_pkg::NE];

    always_comb begin
      for (int l = 0; l < mi3_pkg::NE; l++) begin
        trial[l]   = {rem_r[s][l], low_r[s][l][QB-1]};
        ge[l]      = trial[l] >= {1'b0, dsr_r[s]};
        rem_nxt[l] = ge[l] ? mi3_pkg::DET_W'(trial[l] - {1'b0, dsr_r[s]})
                           : mi3_pkg::DET_W'(trial[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s+1] <= '0;
      end else if (adv) begin
        ctl_r[s+1] <= ctl_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < mi3_pkg::NE; l++) begin
          side_r[s+1][l] <= side_r[s][l];
          quo_r[s+1][l]  <= {quo_r[s][l][QB-2:0], ge[l]};
        end
      end
    end

    if (s < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          dsr_r[s+1] <= dsr_r[s];
          for (int l = 0; l < mi3_pkg::NE; l++) begin
            rem_r[s+1][l] <= rem_nxt[l];
            low_r[s+1][l] <= {low_r[s][l][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign ctl_o  = ctl_r[QB];
  assign side_o = side_r[QB];
  assign quo_o  = quo_r[QB];

endmodule
`default_nettype wire

// File: src/matrix_inverse_3x3.sv
// Top level of the 3x3 fixed-point matrix inverse: pipeline, saturation and output buffer.
//
// Input channel: in_valid / in_stall with nine signed Q16.16 elements in row-major
// order; a transfer happens when in_valid is high and in_stall is low.
// Result channel: out_valid / out_stall with nine signed Q16.16 inverse entries,
// out_singular (zero determinant, entries zero) and out_overflow (some entry
// saturated to the 32-bit signed range). Quotients truncate toward zero.
// Pipeline from an input transfer to out_valid:
// six cofactor/determinant stages, one range-check stage, 33 divider stages (one
// quotient bit each, nine lanes), one saturation stage, then the output register.
// Throughput: one matrix per cycle while in_stall is low, set by the fully pipelined divider lanes.
// Stall: while out_stall holds a result, one more result drops into a skid
// register; in_stall rises when the skid register is full and the whole pipeline
// freezes without loss. in_stall comes from a register only.
// Reset (rst_n low, synchronous) empties all stages, the output and the skid
// register; no other state exists.
`default_nettype none
module matrix_inverse_3x3 (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire mi3_pkg::elem_t in_elem_r0c0,
  input  wire mi3_pkg::elem_t in_elem_r0c1,
  input  wire mi3_pkg::elem_t in_elem_r0c2,
  input  wire mi3_pkg::elem_t in_elem_r1c0,
  input  wire mi3_pkg::elem_t in_elem_r1c1,
  input  wire mi3_pkg::elem_t in_elem_r1c2,
  input  wire mi3_pkg::elem_t in_elem_r2c0,
  input  wire mi3_pkg::elem_t in_elem_r2c1,
  input  wire mi3_pkg::elem_t in_elem_r2c2,
  output logic                out_valid,
  input  wire logic           out_stall,
  output mi3_pkg::elem_t      out_inv_r0c0,
  output mi3_pkg::elem_t      out_inv_r0c1,
  output mi3_pkg::elem_t      out_inv_r0c2,
  output mi3_pkg::elem_t      out_inv_r1c0,
  output mi3_pkg::elem_t      out_inv_r1c1,
  output mi3_pkg::elem_t      out_inv_r1c2,
  output mi3_pkg::elem_t      out_inv_r2c0,
  output mi3_pkg::elem_t      out_inv_r2c1,
  output mi3_pkg::elem_t      out_inv_r2c2,
  output logic                out_singular,
  output logic                out_overflow
);

  logic adv;
  mi3_pkg::elem_t elem_in [mi3_pkg::NE];

  mi3_pkg::item_ctl_t  cof_ctl;
  logic                cof_neg [mi3_pkg::NE];
  mi3_pkg::amag_t      cof_adj [mi3_pkg::NE];
  mi3_pkg::dmag_t      cof_det;

  mi3_pkg::item_ctl_t  div_ctl;
  mi3_pkg::lane_side_t div_side [mi3_pkg::NE];
  mi3_pkg::quo_t       div_quo [mi3_pkg::NE];

  mi3_pkg::res_t fin_nxt;
  mi3_pkg::res_t fin_r;
  logic          fin_valid_r;
  mi3_pkg::res_t out_r;
  logic          out_valid_r;
  mi3_pkg::res_t skid_r;
  logic          skid_valid_r;
  logic          lane_sat;

  // freeze the pipeline ahead of the output register while the skid register holds a result
  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;

  assign elem_in[0] = in_elem_r0c0;
  assign elem_in[1] = in_elem_r0c1;
  assign elem_in[2] = in_elem_r0c2;
  assign elem_in[3] = in_elem_r1c0;
  assign elem_in[4] = in_elem_r1c1;
  assign elem_in[5] = in_elem_r1c2;
  assign elem_in[6] = in_elem_r2c0;
  assign elem_in[7] = in_elem_r2c1;
  assign elem_in[8] = in_elem_r2c2;

  mi3_cofactor u_cofactor (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .valid_i    (in_valid),
    .elem_i     (elem_in),
    .ctl_o      (cof_ctl),
    .lane_neg_o (cof_neg),
    .adj_mag_o  (cof_adj),
    .det_mag_o  (cof_det)
  );

  mi3_divider u_divider (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .ctl_i      (cof_ctl),
    .lane_neg_i (cof_neg),
    .adj_mag_i  (cof_adj),
    .det_mag_i  (cof_det),
    .ctl_o      (div_ctl),
    .side_o     (div_side),
    .quo_o      (div_quo)
  );

  // apply sign, saturate, zero singular results
  always_comb begin
    fin_nxt.singular = div_ctl.singular;
    fin_nxt.overflow = 1'b0;
    lane_sat         = 1'b0;
    for (int l = 0; l < mi3_pkg::NE; l++) begin
      if (div_side[l].neg) begin
        lane_sat       = div_side[l].ovf || (div_quo[l] > mi3_pkg::Q_HALF);
        fin_nxt.inv[l] = lane_sat ? mi3_pkg::ELEM_MIN
                                  : mi3_pkg::elem_t'(mi3_pkg::quo_t'(0) - div_quo[l]);
      end else begin
        lane_sat       = div_side[l].ovf || (div_quo[l] > (mi3_pkg::Q_HALF - mi3_pkg::quo_t'(1)));
        fin_nxt.inv[l] = lane_sat ? mi3_pkg::ELEM_MAX : mi3_pkg::elem_t'(div_quo[l]);
      end
      if (div_ctl.singular) begin
        fin_nxt.inv[l] = '0;
      end else if (lane_sat) begin
        fin_nxt.overflow = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (adv) begin
      fin_valid_r <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_r <= fin_nxt;
    end
  end

  // output register with skid: drain skid first, else take the last stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= fin_valid_r;
      end
    end else if (adv && fin_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= skid_valid_r ? skid_r : fin_r;
    end else if (adv && fin_valid_r) begin
      skid_r <= fin_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_inv_r0c0 = out_r.inv[0];
  assign out_inv_r0c1 = out_r.inv[1];
  assign out_inv_r0c2 = out_r.inv[2];
  assign out_inv_r1c0 = out_r.inv[3];
  assign out_inv_r1c1 = out_r.inv[4];
  assign out_inv_r1c2 = out_r.inv[5];
  assign out_inv_r2c0 = out_r.inv[6];
  assign out_inv_r2c1 = out_r.inv[7];
  assign out_inv_r2c2 = out_r.inv[8];
  assign out_singular = out_r.singular;
  assign out_overflow = out_r.overflow;

`ifndef SYNTHESIS
  // skid register only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled without a stalled output");

  a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("skid result dropped while output stalled");

  a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.singular) |-> (!out_r.overflow && out_r.inv == '0))
    else $error("singular result carries data or overflow");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse.
`default_nettype none
module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    mi3_pkg::elem_t inv [mi3_pkg::NE];
    logic           singular;
    logic           overflow;
  } inverse_t;

  typedef struct {
    mi3_pkg::elem_t m [mi3_pkg::NE];
    logic           has_known;
    inverse_t       known;
  } matrix_row_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  mi3_pkg::elem_t in_m [mi3_pkg::NE];
  logic           out_valid;
  logic           out_stall = 1'b0;
  mi3_pkg::elem_t out_m [mi3_pkg::NE];
  logic           out_singular;
  logic           out_overflow;

  inverse_t expected_q[$];
  int    error_count = 0;
  int    idle_cycles = 0;
  logic  hold_off = 1'b0;
  logic  stim_done = 1'b0;
  matrix_row_t directed [$];

  initial for (int k = 0; k < mi3_pkg::NE; k++) in_m[k] = '0;

  always #4 clk = ~clk;

  matrix_inverse_3x3 dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_elem_r0c0(in_m[0]), .in_elem_r0c1(in_m[1]), .in_elem_r0c2(in_m[2]),
    .in_elem_r1c0(in_m[3]), .in_elem_r1c1(in_m[4]), .in_elem_r1c2(in_m[5]),
    .in_elem_r2c0(in_m[6]), .in_elem_r2c1(in_m[7]), .in_elem_r2c2(in_m[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_inv_r0c0(out_m[0]), .out_inv_r0c1(out_m[1]), .out_inv_r0c2(out_m[2]),
    .out_inv_r1c0(out_m[3]), .out_inv_r1c1(out_m[4]), .out_inv_r1c2(out_m[5]),
    .out_inv_r2c0(out_m[6]), .out_inv_r2c1(out_m[7]), .out_inv_r2c2(out_m[8]),
    .out_singular(out_singular), .out_overflow(out_overflow)
  );

  // Exact adjugate inverse with truncating division and saturation.
  function automatic inverse_t invert_matrix(mi3_pkg::elem_t m [mi3_pkg::NE]);
    inverse_t r;
    wide_t a [mi3_pkg::NE];
    wide_t adj [mi3_pkg::NE];
    wide_t det, num, q, amax, amin;
    a[0] = m[0]; a[1] = m[1]; a[2] = m[2]; a[3] = m[3]; a[4] = m[4];
    a[5] = m[5]; a[6] = m[6]; a[7] = m[7]; a[8] = m[8];
    adj[0] = a[4] * a[8] - a[5] * a[7];
    adj[1] = a[2] * a[7] - a[1] * a[8];
    adj[2] = a[1] * a[5] - a[2] * a[4];
    adj[3] = a[5] * a[6] - a[3] * a[8];
    adj[4] = a[0] * a[8] - a[2] * a[6];
    adj[5] = a[2] * a[3] - a[0] * a[5];
    adj[6] = a[3] * a[7] - a[4] * a[6];
    adj[7] = a[1] * a[6] - a[0] * a[7];
    adj[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
    amax = 256'sd2147483647;
    amin = -256'sd2147483648;
    r.singular = (det == 0);
    r.overflow = 1'b0;
    for (int k = 0; k < mi3_pkg::NE; k++) begin
      if (r.singular) begin
        r.inv[k] = '0;
      end else begin
        num = adj[k] <<< (2 * mi3_pkg::FB);
        q = num / det;
        if (q > amax) begin
          r.inv[k] = mi3_pkg::ELEM_MAX;
          r.overflow = 1'b1;
        end else if (q < amin) begin
          r.inv[k] = mi3_pkg::ELEM_MIN;
          r.overflow = 1'b1;
        end else begin
          r.inv[k] = mi3_pkg::elem_t'(q);
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic mi3_pkg::elem_t random_elem();
    case ($urandom_range(0, 5))
      0: return mi3_pkg::elem_t'($urandom);
      1: return mi3_pkg::elem_t'($urandom_range(0, 3) << 16)
                * ($urandom_range(0, 1) ? -1 : 1);
      2: return mi3_pkg::elem_t'($urandom_range(0, 255)) - 128;
      3: return $urandom_range(0, 1) ? mi3_pkg::ELEM_MAX : mi3_pkg::ELEM_MIN;
      default: return mi3_pkg::elem_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  // Build one row of the directed table.
  function automatic matrix_row_t make_row(int c0, int c1, int c2, int c3, int c4,
                                           int c5, int c6, int c7, int c8);
    matrix_row_t r;
    r.m = '{c0, c1, c2, c3, c4, c5, c6, c7, c8};
    r.has_known = 1'b0;
    return r;
  endfunction

  task automatic build_directed();
    matrix_row_t r;
    // identity inverts to itself
    r = make_row(65536, 0, 0, 0, 65536, 0, 0, 0, 65536);
    r.has_known = 1'b1;
    r.known.inv = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};
    r.known.singular = 0; r.known.overflow = 0;
    directed.push_back(r);
    // zero matrix is singular
    r = make_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    r.has_known = 1'b1;
    r.known.inv = '{default: 0};
    r.known.singular = 1; r.known.overflow = 0;
    directed.push_back(r);
    // repeated rows: singular
    r = make_row(1, 2, 3, 1, 2, 3, 7, 8, 9);
    r.has_known = 1'b1;
    r.known.inv = '{default: 0};
    r.known.singular = 1; r.known.overflow = 0;
    directed.push_back(r);
    // tiny diagonal saturates high
    r = make_row(1, 0, 0, 0, 1, 0, 0, 0, 1);
    r.has_known = 1'b1;
    r.known.inv = '{mi3_pkg::ELEM_MAX, 0, 0, 0, mi3_pkg::ELEM_MAX, 0, 0, 0,
                    mi3_pkg::ELEM_MAX};
    r.known.singular = 0; r.known.overflow = 1;
    directed.push_back(r);
    // tiny negative diagonal saturates low
    r = make_row(-1, 0, 0, 0, -1, 0, 0, 0, -1);
    r.has_known = 1'b1;
    r.known.inv = '{mi3_pkg::ELEM_MIN, 0, 0, 0, mi3_pkg::ELEM_MIN, 0, 0, 0,
                    mi3_pkg::ELEM_MIN};
    r.known.singular = 0; r.known.overflow = 1;
    directed.push_back(r);
    directed.push_back(make_row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                32'h7fffffff));
    directed.push_back(make_row(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0,
                                32'h80000000));
    directed.push_back(make_row(32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0,
                                32'h7fffffff));
    directed.push_back(make_row(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    directed.push_back(make_row(131072, 65536, 0, 65536, 131072, 65536, 0, 65536, 131072));
    directed.push_back(make_row(0, 65536, 0, 0, 0, 65536, 65536, 0, 0));
    directed.push_back(make_row(-196608, 5, 32'h80000000, 7, 32'h7fffffff, -3, 1, 1,
                                98304));
    directed.push_back(make_row(32'h55555555, 32'haaaaaaaa, 1, 2, 32'h55555555,
                                32'haaaaaaaa, 32'haaaaaaaa, 3, 32'h55555555));
  endtask

  // Offer one matrix and hold it until the transfer; valid stays up afterwards.
  task automatic send_matrix(matrix_row_t r);
    inverse_t want;
    want = r.has_known ? r.known : invert_matrix(r.m);
    for (int k = 0; k < mi3_pkg::NE; k++) in_m[k] <= r.m[k];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(want);
  endtask

  // Drop valid for a random number of cycles.
  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus: directed table, then random items with pressure phases.
  initial begin
    matrix_row_t r;
    build_directed();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_matrix(directed[i]);
      sender_gap();
    end
    for (int n = 0; n < 540; n++) begin
      r.has_known = 1'b0;
      for (int k = 0; k < mi3_pkg::NE; k++) r.m[k] = random_elem();
      // sometimes force a dependent row
      if ($urandom_range(0, 9) == 0)
        for (int k = 0; k < 3; k++) r.m[6 + k] = r.m[k];
      if (n == 200) begin
        hold_off <= 1'b1;
      end
      if (n == 350) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
      end
      send_matrix(r);
      if (n < 200 || n > 260) sender_gap();
    end
    in_valid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Receiver stall pattern, with one long hold-off.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_off <= 1'b0;
        @(posedge clk);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
        do @(posedge clk); while (!out_valid && !hold_off);
      end
    end
  end

  // Compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    inverse_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_q.pop_front();
        for (int k = 0; k < mi3_pkg::NE; k++)
          if (out_m[k] !== want.inv[k])
            report_mismatch($sformatf("inv[%0d]", k), out_m[k], want.inv[k]);
        if (out_singular !== want.singular)
          report_mismatch("singular", out_singular, want.singular);
        if (out_overflow !== want.overflow)
          report_mismatch("overflow", out_overflow, want.overflow);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drain and finish.
  initial begin
    @(posedge stim_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: matrix_inverse_3x3.f
src/mi3_pkg.sv
src/mi3_cofactor.sv
src/mi3_divider.sv
src/matrix_inverse_3x3.sv
tb/sv/tb.sv
